// ----- src/xmt_pkg.sv -----
`timescale 1ns / 1ps
// Package for the XML markup tokenizer: beat types, event codes and constants.
// Used by every module of the block; depends on nothing.
package xmt_pkg;

    localparam int TOKEN_MAX_DEF = 32;
    localparam int MAX_DEPTH_DEF = 16;
    localparam int MAX_EVENTS    = 3;
    localparam int ENT_BYTES     = 6;

    // Event codes carried in event_kind.
    localparam logic [3:0] EV_TEXT     = 4'd0;
    localparam logic [3:0] EV_TEXT_END = 4'd1;
    localparam logic [3:0] EV_ATTR     = 4'd2;
    localparam logic [3:0] EV_ATTR_END = 4'd3;
    localparam logic [3:0] EV_NAME     = 4'd4;
    localparam logic [3:0] EV_RESTART  = 4'd5;
    localparam logic [3:0] EV_OPEN     = 4'd6;
    localparam logic [3:0] EV_CLOSE    = 4'd7;
    localparam logic [3:0] EV_ERROR    = 4'd8;

    // Input commands.
    localparam logic CMD_BYTE  = 1'b0;
    localparam logic CMD_CHECK = 1'b1;

    // Register indexes.
    localparam logic REG_KEEP_ATTR  = 1'b0;
    localparam logic REG_SKIP_SPACE = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } in_beat_t;

    typedef struct packed {
        logic [3:0] event_kind;
        logic [7:0] value;
        logic [4:0] nesting;
        logic       last;
    } out_beat_t;

    typedef struct packed {
        logic keep_attributes;
        logic skip_leading_space;
    } cfg_t;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] value;
        logic [4:0] nesting;
    } ev_t;

    typedef struct packed {
        logic [1:0] count;
        ev_t [MAX_EVENTS-1:0] ev;
    } ev_group_t;

    // Appends one event unless an error is latched or the group is full.
    function automatic ev_group_t ev_add(ev_group_t g, logic err, logic [3:0] kind,
                                         logic [7:0] value, logic [4:0] nesting);
        ev_group_t r;
        r = g;
        if (!err && (g.count < 2'(MAX_EVENTS))) begin
            r.ev[g.count].kind    = kind;
            r.ev[g.count].value   = value;
            r.ev[g.count].nesting = nesting;
            r.count               = g.count + 2'd1;
        end
        return r;
    endfunction

endpackage

// ----- src/xmt_cfg.sv -----
`timescale 1ns / 1ps
// Configuration registers of the XML markup tokenizer behind an APB-style port.
// Depends on xmt_pkg.
module xmt_cfg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output xmt_pkg::cfg_t cfg
);
    import xmt_pkg::*;

    logic keep_reg, skip_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes land on the access cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_reg <= 1'b1;
            skip_reg <= 1'b1;
        end else if (wr_en) begin
            case (paddr[2])
                REG_KEEP_ATTR:  keep_reg <= pwdata[0];
                REG_SKIP_SPACE: skip_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back.
    always_comb begin
        case (paddr[2])
            REG_KEEP_ATTR:  prdata = {31'd0, keep_reg};
            REG_SKIP_SPACE: prdata = {31'd0, skip_reg};
            default:        prdata = 32'd0;
        endcase
    end

    assign cfg.keep_attributes    = keep_reg;
    assign cfg.skip_leading_space = skip_reg;

endmodule

// ----- src/xmt_core.sv -----
`timescale 1ns / 1ps
// Per-byte parser of the XML markup tokenizer: state, token and name stack.
// Produces the group of events of each accepted beat; depends on xmt_pkg.
module xmt_core #(
    parameter int TOKEN_MAX = xmt_pkg::TOKEN_MAX_DEF,
    parameter int MAX_DEPTH = xmt_pkg::MAX_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  xmt_pkg::cfg_t       cfg,
    input  logic                in_take,
    input  xmt_pkg::in_beat_t   in_beat,
    output xmt_pkg::ev_group_t  evs
);
    import xmt_pkg::*;

    localparam int CW = $clog2(TOKEN_MAX + 1);
    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int RW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int SD = MAX_DEPTH * TOKEN_MAX;
    localparam int AW = $clog2(SD);

    // Parse phases.
    localparam logic [6:0] P_OUT   = 7'd0;
    localparam logic [6:0] P_LT    = 7'd10;
    localparam logic [6:0] P_NAME0 = 7'd11;
    localparam logic [6:0] P_NAME  = 7'd20;
    localparam logic [6:0] P_NAMEC = 7'd21;
    localparam logic [6:0] P_ATTR0 = 7'd30;
    localparam logic [6:0] P_ATTR  = 7'd31;
    localparam logic [6:0] P_SLASH = 7'd40;
    localparam logic [6:0] P_PI    = 7'd50;
    localparam logic [6:0] P_PIQ   = 7'd55;
    localparam logic [6:0] P_BANG  = 7'd60;
    localparam logic [6:0] P_CM0   = 7'd61;
    localparam logic [6:0] P_CM    = 7'd62;
    localparam logic [6:0] P_CMD1  = 7'd63;
    localparam logic [6:0] P_CMD2  = 7'd64;
    localparam logic [6:0] P_CD0   = 7'd100;
    localparam logic [6:0] P_CD5   = 7'd105;
    localparam logic [6:0] P_CDT   = 7'd106;
    localparam logic [6:0] P_CB1   = 7'd107;
    localparam logic [6:0] P_CB2   = 7'd108;

    // Text phases.
    localparam logic [1:0] T_LEAD = 2'd0;
    localparam logic [1:0] T_BODY = 2'd1;
    localparam logic [1:0] T_ENT  = 2'd2;

    function automatic logic is_space(logic [7:0] c);
        return (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D) || (c == 8'h20);
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic [7:0] cdata_char(logic [6:0] ph);
        logic [7:0] r;
        case (ph - P_CD0)
            7'd0:    r = "C";
            7'd1:    r = "D";
            7'd2:    r = "A";
            7'd3:    r = "T";
            7'd4:    r = "A";
            default: r = "[";
        endcase
        return r;
    endfunction

    // State registers.
    logic [6:0]    ph_reg, ph_next;
    logic [1:0]    tph_reg, tph_next;
    logic          closing_reg, closing_next;
    logic          quote_reg, quote_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic          match_reg, match_next;
    logic          pend_reg, pend_next;
    logic          err_reg, err_next;
    logic [7:0]    tok_reg [ENT_BYTES];
    logic [7:0]    tok_next [ENT_BYTES];

    // Name stack and lengths, with the top entry fetched one beat ahead.
    logic [7:0]    stack_mem [SD];
    logic [CW-1:0] len_mem [MAX_DEPTH];
    logic [7:0]    stack_rd_reg;
    logic [CW-1:0] len_top_reg;
    logic          stack_we;
    logic [AW-1:0] stack_waddr;
    logic [7:0]    stack_wdata;
    logic          len_we;
    logic [RW-1:0] len_waddr;
    logic [AW-1:0] stack_raddr;
    logic [RW-1:0] len_raddr;

    ev_group_t g;
    logic [7:0] c;
    logic       do11, do21, do31, do_push, push_attr, ok;

    // Next state and events of one beat.
    always_comb begin
        ph_next      = ph_reg;
        tph_next     = tph_reg;
        closing_next = closing_reg;
        quote_next   = quote_reg;
        cnt_next     = cnt_reg;
        depth_next   = depth_reg;
        match_next   = match_reg;
        pend_next    = pend_reg;
        err_next     = err_reg;
        for (int i = 0; i < ENT_BYTES; i++) tok_next[i] = tok_reg[i];
        g            = '0;
        c            = in_beat.data_byte;
        do11         = 1'b0;
        do21         = 1'b0;
        do31         = 1'b0;
        do_push      = 1'b0;
        push_attr    = 1'b0;
        ok           = 1'b1;
        stack_we     = 1'b0;
        stack_waddr  = '0;
        stack_wdata  = c;
        len_we       = 1'b0;
        len_waddr    = '0;

        if (in_beat.cmd == CMD_CHECK) begin
            // End of document check.
            if (err_reg) begin
                g        = ev_add(g, 1'b0, EV_ERROR, 8'd0, 5'(depth_next));
                err_next = 1'b1;
            end else if ((cnt_reg != '0) || (ph_reg != P_OUT)) begin
                g        = ev_add(g, 1'b0, EV_ERROR, 8'd0, 5'(depth_next));
                err_next = 1'b1;
            end else begin
                if (pend_reg) g = ev_add(g, 1'b0, EV_TEXT_END, 8'd0, 5'(depth_next));
                pend_next = 1'b0;
            end
        end else if (!err_reg) begin
            case (ph_reg)
                P_OUT: begin
                    if (c == "<") begin
                        ph_next = P_LT;
                        if (pend_reg) g = ev_add(g, 1'b0, EV_TEXT_END, 8'd0, 5'(depth_next));
                        pend_next  = 1'b0;
                        cnt_next   = '0;
                        match_next = 1'b1;
                        tph_next   = T_LEAD;
                    end else if (!((tph_reg == T_LEAD) && cfg.skip_leading_space
                                   && is_space(c))) begin
                        // Text content with entity decoding.
                        if ((tph_reg == T_LEAD) || (tph_reg == T_BODY)) begin
                            if (c == "&") begin
                                if (cnt_reg >= CW'(TOKEN_MAX)) begin
                                    g        = ev_add(g, 1'b0, EV_ERROR, 8'd0, 5'(depth_next));
                                    err_next = 1'b1;
                                end else begin
                                    if (cnt_reg < CW'(ENT_BYTES))
                                        tok_next[cnt_reg[2:0]] = c;
                                    cnt_next = cnt_reg + 1'b1;
                                    tph_next = T_ENT;
                                end
                            end else begin
                                g         = ev_add(g, 1'b0, EV_TEXT, c, 5'(depth_next));
                                pend_next = 1'b1;
                                tph_next  = T_BODY;
                            end
                        end else if (cnt_reg >= CW'(TOKEN_MAX)) begin
                            g        = ev_add(g, 1'b0, EV_ERROR, 8'd0, 5'(depth_next));
                            err_next = 1'b1;
                        end else begin
                            if (cnt_reg < CW'(ENT_BYTES)) tok_next[cnt_reg[2:0]] = c;
                            cnt_next = cnt_reg + 1'b1;
                            if (c == ";") begin
                                if ((cnt_next == CW'(4)) && (tok_next[1] == "l")
                                    && (tok_next[2] == "t")) begin
                                    g = ev_add(g, 1'b0, EV_TEXT, "<", 5'(depth_next));
                                    pend_next = 1'b1;
                                end else if ((cnt_next == CW'(4)) && (tok_next[1] == "g")
                                             && (tok_next[2] == "t")) begin
                                    g = ev_add(g, 1'b0, EV_TEXT, ">", 5'(depth_next));
                                    pend_next = 1'b1;
                                end else if ((cnt_next == CW'(6)) && (tok_next[1] == "a")
                                             && (tok_next[2] == "p") && (tok_next[3] == "o")
                                             && (tok_next[4] == "s")) begin
                                    g = ev_add(g, 1'b0, EV_TEXT, "'", 5'(depth_next));
                                    pend_next = 1'b1;
                                end else if ((cnt_next == CW'(6)) && (tok_next[1] == "q")
                                             && (tok_next[2] == "u") && (tok_next[3] == "o")
                                             && (tok_next[4] == "t")) begin
                                    g = ev_add(g, 1'b0, EV_TEXT, "\"", 5'(depth_next));
                                    pend_next = 1'b1;
                                end else if ((cnt_next == CW'(5)) && (tok_next[1] == "a")
                                             && (tok_next[2] == "m") && (tok_next[3] == "p"))
                                begin
                                    g = ev_add(g, 1'b0, EV_TEXT, "&", 5'(depth_next));
                                    pend_next = 1'b1;
                                end
                                cnt_next   = '0;
                                match_next = 1'b1;
                                tph_next   = T_BODY;
                            end
                        end
                    end
                end
                P_LT: begin
                    if (c == "/") begin
                        ph_next      = P_NAME;
                        closing_next = 1'b1;
                    end else if (c == "?") begin
                        ph_next = P_PI;
                    end else if (c == "!") begin
                        ph_next = P_BANG;
                    end else begin
                        ph_next = P_NAME0;
                        do11    = 1'b1;
                    end
                end
                P_NAME0: do11 = 1'b1;
                P_NAME: begin
                    if (!is_space(c)) begin
                        ph_next = P_NAMEC;
                        do21    = 1'b1;
                    end
                end
                P_NAMEC: do21 = 1'b1;
                P_ATTR0: begin
                    if (c != " ") begin
                        ph_next = P_ATTR;
                        do31    = 1'b1;
                    end
                end
                P_ATTR: do31 = 1'b1;
                P_SLASH: begin
                    if (c != ">") begin
                        g        = ev_add(g, 1'b0, EV_ERROR, 8'd0, 5'(depth_next));
                        err_next = 1'b1;
                    end else begin
                        do_push = 1'b1;
                    end
                end
                P_PI:  if (c == "?") ph_next = P_PIQ;
                P_PIQ: begin
                    if (c == ">") ph_next = P_OUT;
                    else if (c != "?") ph_next = P_PI;
                end
                P_BANG: begin
                    if (c == "-") ph_next = P_CM0;
                    else if (c == "[") ph_next = P_CD0;
                    else begin
                        g        = ev_add(g, 1'b0, EV_ERROR, 8'd0, 5'(depth_next));
                        err_next = 1'b1;
                    end
                end
                P_CM0: begin
                    if (c == "-") ph_next = P_CM;
                    else begin
                        g        = ev_add(g, 1'b0, EV_ERROR, 8'd0, 5'(depth_next));
                        err_next = 1'b1;
                    end
                end
                P_CM:   if (c == "-") ph_next = P_CMD1;
                P_CMD1: ph_next = (c == "-") ? P_CMD2 : P_CM;
                P_CMD2: begin
                    if (c == ">") ph_next = P_OUT;
                    else if (c != "-") ph_next = P_CM;
                end
                P_CDT: begin
                    if (c == "]") ph_next = P_CB1;
                    else begin
                        g         = ev_add(g, 1'b0, EV_TEXT, c, 5'(depth_next));
                        pend_next = 1'b1;
                    end
                end
                P_CB1: begin
                    if (c == "]") ph_next = P_CB2;
                    else begin
                        g         = ev_add(g, 1'b0, EV_TEXT, "]", 5'(depth_next));
                        g         = ev_add(g, 1'b0, EV_TEXT, c, 5'(depth_next));
                        pend_next = 1'b1;
                        ph_next   = P_CDT;
                    end
                end
                P_CB2: begin
                    if (c == ">") begin
                        ph_next = P_OUT;
                        if (pend_reg) g = ev_add(g, 1'b0, EV_TEXT_END, 8'd0, 5'(depth_next));
                        pend_next = 1'b0;
                    end else if (c == "]") begin
                        g         = ev_add(g, 1'b0, EV_TEXT, c, 5'(depth_next));
                        pend_next = 1'b1;
                    end else begin
                        g         = ev_add(g, 1'b0, EV_TEXT, "]", 5'(depth_next));
                        g         = ev_add(g, 1'b0, EV_TEXT, "]", 5'(depth_next));
                        g         = ev_add(g, 1'b0, EV_TEXT, c, 5'(depth_next));
                        pend_next = 1'b1;
                        ph_next   = P_CDT;
                    end
                end
                default: begin
                    // CDATA keyword, else a phase that is never set.
                    if ((ph_reg >= P_CD0) && (ph_reg <= P_CD5)) begin
                        if (c == cdata_char(ph_reg)) ph_next = ph_reg + 7'd1;
                        else begin
                            g        = ev_add(g, 1'b0, EV_ERROR, 8'd0, 5'(depth_next));
                            err_next = 1'b1;
                        end
                    end else begin
                        ph_next = P_OUT;
                    end
                end
            endcase

            // First byte of a tag name.
            if (do11 && !is_space(c)) begin
                if (is_alpha(c)) begin
                    do21    = 1'b0;
                    ph_next = P_NAME;
                end else begin
                    g        = ev_add(g, 1'b0, EV_ERROR, 8'd0, 5'(depth_next));
                    err_next = 1'b1;
                end
            end

            // Tag name body, name bytes included.
            if (do21) begin
                if (c == ":") begin
                    cnt_next   = '0;
                    match_next = 1'b1;
                    g = ev_add(g, 1'b0, EV_RESTART, 8'd0, 5'(depth_next));
                end else if (is_space(c)) begin
                    do_push   = 1'b1;
                    push_attr = 1'b1;
                end else if (is_alpha(c) || is_digit(c) || (c == "_") || (c == "-")) begin
                    do11 = 1'b1;
                end else if (c == "/") begin
                    ph_next = P_SLASH;
                end else if (c == ">") begin
                    do_push = 1'b1;
                end else begin
                    g        = ev_add(g, 1'b0, EV_ERROR, 8'd0, 5'(depth_next));
                    err_next = 1'b1;
                end
            end

            // One name byte: close tag check, token add, stack write.
            if (do11 && (is_alpha(c) || (do21 && (is_digit(c) || (c == "_") || (c == "-"))))
                && !err_next) begin
                if (closing_reg) begin
                    if ((depth_reg == '0) || (cnt_reg >= CW'(TOKEN_MAX)))
                        match_next = 1'b0;
                    else if ((cnt_reg >= len_top_reg) || (stack_rd_reg != c))
                        match_next = 1'b0;
                end
                if (cnt_reg >= CW'(TOKEN_MAX)) begin
                    g        = ev_add(g, 1'b0, EV_ERROR, 8'd0, 5'(depth_next));
                    err_next = 1'b1;
                end else begin
                    if (cnt_reg < CW'(ENT_BYTES)) tok_next[cnt_reg[2:0]] = c;
                    cnt_next = cnt_reg + 1'b1;
                    g = ev_add(g, 1'b0, EV_NAME, c, 5'(depth_next));
                    if (!closing_reg && (depth_reg < DW'(MAX_DEPTH))) begin
                        stack_we    = 1'b1;
                        stack_waddr = AW'(depth_reg) * AW'(TOKEN_MAX) + AW'(cnt_reg);
                    end
                end
            end

            // Tag complete: open, close, or both for a self closing tag.
            if (do_push) begin
                if (ph_reg == P_SLASH) begin
                    if (cnt_reg != '0) begin
                        if (depth_next >= DW'(MAX_DEPTH)) begin
                            g = ev_add(g, 1'b0, EV_ERROR, 8'd0, 5'(depth_next));
                            err_next = 1'b1;
                            ok = 1'b0;
                        end else begin
                            len_we     = 1'b1;
                            len_waddr  = RW'(depth_next);
                            depth_next = depth_next + 1'b1;
                            g = ev_add(g, 1'b0, EV_OPEN, 8'd0, 5'(depth_next));
                        end
                    end
                    if (ok) begin
                        if (depth_next == '0) begin
                            g = ev_add(g, 1'b0, EV_ERROR, 8'd0, 5'(depth_next));
                            err_next = 1'b1;
                            ok = 1'b0;
                        end else begin
                            depth_next = depth_next - 1'b1;
                            g = ev_add(g, 1'b0, EV_CLOSE, 8'd0, 5'(depth_next));
                        end
                    end
                end else if (closing_reg) begin
                    if ((depth_reg == '0) || ((cnt_reg != '0)
                        && !(match_reg && (cnt_reg == len_top_reg)))) begin
                        g = ev_add(g, 1'b0, EV_ERROR, 8'd0, 5'(depth_next));
                        err_next = 1'b1;
                        ok = 1'b0;
                    end else begin
                        depth_next = depth_reg - 1'b1;
                        g = ev_add(g, 1'b0, EV_CLOSE, 8'd0, 5'(depth_next));
                    end
                end else begin
                    if ((cnt_reg == '0) || (depth_reg >= DW'(MAX_DEPTH))) begin
                        g = ev_add(g, 1'b0, EV_ERROR, 8'd0, 5'(depth_next));
                        err_next = 1'b1;
                        ok = 1'b0;
                    end else begin
                        len_we     = 1'b1;
                        len_waddr  = RW'(depth_reg);
                        depth_next = depth_reg + 1'b1;
                        g = ev_add(g, 1'b0, EV_OPEN, 8'd0, 5'(depth_next));
                    end
                end
                if (ok) begin
                    cnt_next     = '0;
                    match_next   = 1'b1;
                    closing_next = 1'b0;
                    quote_next   = 1'b0;
                    ph_next      = push_attr ? P_ATTR0 : P_OUT;
                end
            end

            // Attribute text, passed through raw.
            if (do31) begin
                if (quote_reg) begin
                    if (c == "\"") quote_next = 1'b0;
                end else if (c == "\"") begin
                    quote_next = 1'b1;
                end else if ((c == "/") || (c == ">")) begin
                    ph_next = (c == "/") ? P_SLASH : P_OUT;
                    if (cfg.keep_attributes) begin
                        if (pend_reg) g = ev_add(g, 1'b0, EV_ATTR_END, 8'd0, 5'(depth_next));
                        pend_next = 1'b0;
                    end
                end
                if (cfg.keep_attributes && (ph_next == P_ATTR)) begin
                    g         = ev_add(g, 1'b0, EV_ATTR, c, 5'(depth_next));
                    pend_next = 1'b1;
                end
            end
        end
    end

    // Prefetch address for the top entry as seen by the next beat.
    always_comb begin
        stack_raddr = '0;
        len_raddr   = '0;
        if ((depth_next != '0) && (depth_next <= DW'(MAX_DEPTH))) begin
            len_raddr = RW'(depth_next - 1'b1);
            if (cnt_next < CW'(TOKEN_MAX))
                stack_raddr = AW'(depth_next - 1'b1) * AW'(TOKEN_MAX) + AW'(cnt_next);
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg      <= P_OUT;
            tph_reg     <= T_LEAD;
            closing_reg <= 1'b0;
            quote_reg   <= 1'b0;
            cnt_reg     <= '0;
            depth_reg   <= '0;
            match_reg   <= 1'b1;
            pend_reg    <= 1'b0;
            err_reg     <= 1'b0;
        end else if (in_take) begin
            ph_reg      <= ph_next;
            tph_reg     <= tph_next;
            closing_reg <= closing_next;
            quote_reg   <= quote_next;
            cnt_reg     <= cnt_next;
            depth_reg   <= depth_next;
            match_reg   <= match_next;
            pend_reg    <= pend_next;
            err_reg     <= err_next;
        end
    end

    // Token bytes, name stack and lengths.
    always_ff @(posedge aclk) begin
        if (in_take) begin
            for (int i = 0; i < ENT_BYTES; i++) tok_reg[i] <= tok_next[i];
            if (stack_we) stack_mem[stack_waddr] <= stack_wdata;
            if (len_we) len_mem[len_waddr] <= cnt_reg;
        end
        stack_rd_reg <= stack_mem[in_take ? stack_raddr
                                  : ((depth_reg != '0) && (cnt_reg < CW'(TOKEN_MAX))
                                     ? AW'(depth_reg - 1'b1) * AW'(TOKEN_MAX) + AW'(cnt_reg)
                                     : '0)];
        if (in_take && len_we && (len_waddr == len_raddr))
            len_top_reg <= cnt_reg;
        else
            len_top_reg <= len_mem[in_take ? len_raddr
                                   : ((depth_reg != '0) ? RW'(depth_reg - 1'b1) : '0)];
    end

    assign evs = in_take ? g : '0;

endmodule

// ----- src/xmt_evbuf.sv -----
`timescale 1ns / 1ps
// Result register of the XML markup tokenizer: holds one beat's event group
// and hands its events out one per output beat. Depends on xmt_pkg.
module xmt_evbuf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  xmt_pkg::ev_group_t  evs,
    output logic                free,
    output logic                m_valid,
    input  logic                m_ready,
    output xmt_pkg::out_beat_t  m_data
);
    import xmt_pkg::*;

    ev_group_t  grp_reg;
    logic [1:0] idx_reg;
    logic       valid_reg;
    logic       is_last;

    assign is_last = (idx_reg == (grp_reg.count - 2'd1));
    assign free    = !valid_reg || (m_ready && is_last);

    // Load a new group as the old one drains.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (load && free) begin
            valid_reg <= (evs.count != 2'd0);
            idx_reg   <= '0;
        end else if (valid_reg && m_ready) begin
            valid_reg <= !is_last;
            idx_reg   <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && free) grp_reg <= evs;
    end

    assign m_valid           = valid_reg;
    assign m_data.event_kind = grp_reg.ev[idx_reg].kind;
    assign m_data.value      = grp_reg.ev[idx_reg].value;
    assign m_data.nesting    = grp_reg.ev[idx_reg].nesting;
    assign m_data.last       = is_last;

endmodule

// ----- src/xml_markup_tokenizer.sv -----
`timescale 1ns / 1ps
// Top level of the XML markup tokenizer: configuration port, parser, result register.
// Depends on xmt_pkg, xmt_cfg, xmt_core and xmt_evbuf.
//
// Usage: one document byte (cmd 0) or one end of document check (cmd 1) per
// input beat on s_*. Each beat yields zero to three events on m_*, in order,
// the final one of a beat marked by last. The parser handles a beat in the
// cycle it is accepted; its events are registered and appear on m_* in the
// next cycle, one per cycle while m_ready is high. The block takes a byte
// every cycle while each byte gives at most one event and the receiver does
// not stall; otherwise the three-slot result register holds new beats back
// until the last event of the previous one is being delivered. When the
// receiver stalls, the events hold and s_ready falls once the result register
// cannot drain. Reset returns the parser to plain text, depth zero, with
// attributes kept and leading space skipped. The name stack is a memory read
// one beat ahead; it needs no clearing. Configuration is to be written
// through the APB port while the block is idle; the block does not enforce it.
module xml_markup_tokenizer #(
    parameter int TOKEN_MAX = xmt_pkg::TOKEN_MAX_DEF,
    parameter int MAX_DEPTH = xmt_pkg::MAX_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  xmt_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output xmt_pkg::out_beat_t m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import xmt_pkg::*;

    cfg_t      cfg;
    ev_group_t evs;
    logic      free;
    logic      take;

    assign s_ready = free;
    assign take    = s_valid && free;

    // Register block.
    xmt_cfg u_cfg (
        .aclk(aclk), .aresetn(aresetn), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .cfg(cfg)
    );

    // Parser.
    xmt_core #(.TOKEN_MAX(TOKEN_MAX), .MAX_DEPTH(MAX_DEPTH)) u_core (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg), .in_take(take),
        .in_beat(s_data), .evs(evs)
    );

    // Result register.
    xmt_evbuf u_evbuf (
        .aclk(aclk), .aresetn(aresetn), .load(take), .evs(evs), .free(free),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // A beat is taken only when the pending events are gone or finishing.
    a_take_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> (!m_valid || (m_ready && m_data.last)))
        else $error("input beat taken over undelivered events");

    // An error event always ends its group.
    a_error_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.event_kind == EV_ERROR)) |-> m_data.last)
        else $error("error event not last");

    // Nothing is offered right after reset.
    a_reset_idle: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("output valid after reset");

endmodule
